>>> rtl/core/stc_pkg.sv
// Shared types, constants and character helpers for the SQL token classifier.
package stc_pkg;

    localparam int MAX_TOKEN_LEN_DEF = 1023;
    localparam int NUM_WORDS         = 27;
    localparam int NUM_KEYWORDS      = 24;

    localparam logic [3:0] CLS_UNKNOWN    = 4'd0;
    localparam logic [3:0] CLS_KEYWORD    = 4'd1;
    localparam logic [3:0] CLS_NUMBER     = 4'd2;
    localparam logic [3:0] CLS_STRING     = 4'd3;
    localparam logic [3:0] CLS_OPERATOR   = 4'd4;
    localparam logic [3:0] CLS_COMMA      = 4'd5;
    localparam logic [3:0] CLS_PAREN      = 4'd6;
    localparam logic [3:0] CLS_SEMICOLON  = 4'd7;
    localparam logic [3:0] CLS_SELECT_ITM = 4'd8;
    localparam logic [3:0] CLS_IDENT      = 4'd9;
    localparam logic [3:0] CLS_COMMENT    = 4'd10;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_QUOTE = 8'h27;
    localparam logic [7:0] CH_LPAR  = 8'h28;
    localparam logic [7:0] CH_RPAR  = 8'h29;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_LBRK  = 8'h5B;
    localparam logic [7:0] CH_RBRK  = 8'h5D;
    localparam logic [7:0] CH_UNDER = 8'h5F;

    // lower-case word text, first character in the most significant used byte
    localparam logic [47:0] WORD_TEXT [NUM_WORDS] = '{
        48'("select"), 48'("from"), 48'("where"), 48'("insert"), 48'("update"),
        48'("delete"), 48'("create"), 48'("drop"), 48'("alter"), 48'("join"),
        48'("on"), 48'("group"), 48'("order"), 48'("left"), 48'("right"),
        48'("inner"), 48'("by"), 48'("as"), 48'("into"), 48'("with"),
        48'("union"), 48'("limit"), 48'("offset"), 48'("having"), 48'("and"),
        48'("or"), 48'("not")
    };
    localparam logic [2:0] WORD_LEN [NUM_WORDS] = '{
        3'd6, 3'd4, 3'd5, 3'd6, 3'd6, 3'd6, 3'd6, 3'd4, 3'd5, 3'd4, 3'd2,
        3'd5, 3'd5, 3'd4, 3'd5, 3'd5, 3'd2, 3'd2, 3'd4, 3'd4, 3'd5, 3'd5,
        3'd6, 3'd6, 3'd3, 3'd2, 3'd3
    };

    typedef struct packed {
        logic [7:0] text_byte;
        logic       start_of_text;
    } t_in_item;

    typedef struct packed {
        logic [3:0]  token_class;
        logic [15:0] line_index;
        logic [9:0]  clean_length;
        logic [9:0]  byte_length;
        logic [15:0] token_index;
    } t_out_item;

    // what the classifier needs to know about a finished token
    typedef struct packed {
        logic [7:0]           t0;
        logic [7:0]           t1;
        logic [7:0]           last;
        logic [NUM_WORDS-1:0] words;
        logic [15:0]          len;
        logic                 num_ok;
        logic                 ident_ok;
        logic                 has_comma;
        logic                 in_comment;
    } t_tok_snap;

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        logic [7:0] r;
        r = (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
        return r;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_alnum(input logic [7:0] c);
        return is_digit(c) || (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic logic is_ident_byte(input logic [7:0] c);
        return is_alnum(c) || c == CH_UNDER || c == CH_LBRK || c == CH_RBRK ||
               c == CH_COMMA || c == CH_DOT || c == CH_STAR || c == CH_LPAR ||
               c == CH_RPAR;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR;
    endfunction

    // character of word k at position pos; only meaningful for pos < WORD_LEN[k]
    function automatic logic [7:0] word_char(input int k, input logic [2:0] pos);
        logic [2:0] sel;
        sel = WORD_LEN[k] - 3'd1 - pos;
        return WORD_TEXT[k][8*sel +: 8];
    endfunction

endpackage

>>> rtl/core/stc_classify.sv
// Priority classifier for one finished token.
module stc_classify (
    input  stc_pkg::t_tok_snap i_snap,
    output logic [3:0]         o_class
);
    import stc_pkg::*;

    logic       len1;
    logic       len2;
    logic       len_ge2;
    logic [NUM_WORDS-1:0] hit;

    always_comb begin
        for (int k = 0; k < NUM_WORDS; k++) begin
            hit[k] = i_snap.words[k] && (i_snap.len == 16'(WORD_LEN[k]));
        end
    end

    assign len1    = (i_snap.len == 16'd1);
    assign len2    = (i_snap.len == 16'd2);
    assign len_ge2 = (i_snap.len >= 16'd2);

    always_comb begin
        if (i_snap.in_comment) begin
            o_class = CLS_COMMENT;
        end else if (len_ge2 && i_snap.t0 == CH_MINUS && i_snap.t1 == CH_MINUS) begin
            o_class = CLS_COMMENT;
        end else if (|hit[NUM_KEYWORDS-1:0]) begin
            o_class = CLS_KEYWORD;
        end else if ((is_digit(i_snap.t0) ||
                      (i_snap.t0 == CH_MINUS && len_ge2 && is_digit(i_snap.t1))) &&
                     i_snap.num_ok) begin
            o_class = CLS_NUMBER;
        end else if (len_ge2 && i_snap.t0 == CH_QUOTE && i_snap.last == CH_QUOTE) begin
            o_class = CLS_STRING;
        end else if (len1 && (i_snap.t0 == CH_PLUS || i_snap.t0 == CH_MINUS ||
                              i_snap.t0 == CH_STAR || i_snap.t0 == CH_SLASH ||
                              i_snap.t0 == CH_EQ || i_snap.t0 == CH_LT ||
                              i_snap.t0 == CH_GT)) begin
            o_class = CLS_OPERATOR;
        end else if (len2 && ((i_snap.t1 == CH_EQ && (i_snap.t0 == CH_LT ||
                               i_snap.t0 == CH_GT || i_snap.t0 == CH_BANG)) ||
                              (i_snap.t0 == CH_LT && i_snap.t1 == CH_GT))) begin
            o_class = CLS_OPERATOR;
        end else if (|hit[NUM_WORDS-1:NUM_KEYWORDS]) begin
            o_class = CLS_OPERATOR;
        end else if (len1 && i_snap.t0 == CH_COMMA) begin
            o_class = CLS_COMMA;
        end else if (len1 && (i_snap.t0 == CH_LPAR || i_snap.t0 == CH_RPAR)) begin
            o_class = CLS_PAREN;
        end else if (len1 && i_snap.t0 == CH_SEMI) begin
            o_class = CLS_SEMICOLON;
        end else if (is_alnum(i_snap.t0) || i_snap.t0 == CH_UNDER ||
                     i_snap.t0 == CH_COMMA || i_snap.t0 == CH_LBRK ||
                     i_snap.t0 == CH_RBRK) begin
            if (!i_snap.ident_ok) begin
                o_class = CLS_UNKNOWN;
            end else begin
                o_class = i_snap.has_comma ? CLS_SELECT_ITM : CLS_IDENT;
            end
        end else begin
            o_class = CLS_UNKNOWN;
        end
    end

endmodule

>>> rtl/core/stc_scan.sv
// Per-byte token state: running match flags, counters, line and comment tracking.
module stc_scan #(
    parameter int MAX_TOKEN_LEN = stc_pkg::MAX_TOKEN_LEN_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  stc_pkg::t_in_item i_item,
    input  logic [15:0]       i_first_idx,
    output logic              o_emit,
    output stc_pkg::t_out_item o_res
);
    import stc_pkg::*;

    localparam int CW = $clog2(MAX_TOKEN_LEN + 1);
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_TOKEN_LEN);

    logic [CW-1:0]        r_byte_cnt, r_comma_cnt, r_clean_cnt;
    logic [CW-1:0]        n_byte_cnt, n_comma_cnt, n_clean_cnt;
    logic [15:0]          r_first, r_last, n_first, n_last;
    logic [NUM_WORDS-1:0] r_words, n_words;
    logic                 r_num_ok, r_ident_ok, r_has_comma;
    logic                 n_num_ok, n_ident_ok, n_has_comma;
    logic [15:0]          r_line, n_line, r_lc_line, n_lc_line, r_tok_cnt, n_tok_cnt;
    logic                 r_cm_in, r_cm_block, r_cm_linev;
    logic                 n_cm_in, n_cm_block, n_cm_linev;

    // state as seen after an optional start-of-text clear
    logic [CW-1:0]        c_byte_cnt, c_comma_cnt, c_clean_cnt;
    logic [15:0]          c_first, c_last, c_line, c_lc_line, c_tok_cnt;
    logic [NUM_WORDS-1:0] c_words;
    logic                 c_num_ok, c_ident_ok, c_has_comma;
    logic                 c_cm_in, c_cm_block, c_cm_linev;

    logic [7:0]  b;
    logic        sot;
    logic        ws;
    logic [15:0] pos16, clean16;
    logic        open_blk, open_line, close_blk;
    logic        cm_in_cls;
    logic [15:0] line_inc;
    t_tok_snap   snap;
    logic [3:0]  cls;

    assign b   = i_item.text_byte;
    assign sot = i_item.start_of_text;
    assign ws  = is_space(b);

    always_comb begin
        c_byte_cnt  = sot ? '0 : r_byte_cnt;
        c_comma_cnt = sot ? '0 : r_comma_cnt;
        c_clean_cnt = sot ? '0 : r_clean_cnt;
        c_first     = sot ? '0 : r_first;
        c_last      = sot ? '0 : r_last;
        c_words     = sot ? '1 : r_words;
        c_num_ok    = sot ? 1'b1 : r_num_ok;
        c_ident_ok  = sot ? 1'b1 : r_ident_ok;
        c_has_comma = sot ? 1'b0 : r_has_comma;
        c_line      = sot ? '0 : r_line;
        c_lc_line   = sot ? '0 : r_lc_line;
        c_tok_cnt   = sot ? i_first_idx : r_tok_cnt;
        c_cm_in     = sot ? 1'b0 : r_cm_in;
        c_cm_block  = sot ? 1'b0 : r_cm_block;
        c_cm_linev  = sot ? 1'b0 : r_cm_linev;
    end

    assign pos16   = 16'(c_byte_cnt);
    assign clean16 = 16'(c_clean_cnt);
    assign o_emit  = ws && (c_byte_cnt != '0);

    assign open_blk  = (pos16 > 16'd1) && c_first[7:0] == CH_SLASH && c_first[15:8] == CH_STAR;
    assign open_line = (pos16 > 16'd1) && c_first[7:0] == CH_MINUS && c_first[15:8] == CH_MINUS;
    assign close_blk = (pos16 > 16'd1) && c_last[15:8] == CH_STAR && c_last[7:0] == CH_SLASH;
    assign cm_in_cls = c_cm_in || open_blk || open_line;
    assign line_inc  = (c_line != 16'hFFFF) ? c_line + 16'd1 : c_line;

    always_comb begin
        snap.t0         = c_first[7:0];
        snap.t1         = c_first[15:8];
        snap.last       = c_last[7:0];
        snap.words      = c_words;
        snap.len        = pos16;
        snap.num_ok     = c_num_ok;
        snap.ident_ok   = c_ident_ok;
        snap.has_comma  = c_has_comma;
        snap.in_comment = cm_in_cls;
    end

    stc_classify u_classify (
        .i_snap  (snap),
        .o_class (cls)
    );

    always_comb begin
        o_res.token_class  = cls;
        o_res.line_index   = c_line;
        o_res.clean_length = (clean16 > 16'd1023) ? 10'd1023 : clean16[9:0];
        o_res.byte_length  = (pos16 > 16'd1023) ? 10'd1023 : pos16[9:0];
        o_res.token_index  = c_tok_cnt;
    end

    always_comb begin
        n_byte_cnt  = c_byte_cnt;
        n_comma_cnt = c_comma_cnt;
        n_clean_cnt = c_clean_cnt;
        n_first     = c_first;
        n_last      = c_last;
        n_words     = c_words;
        n_num_ok    = c_num_ok;
        n_ident_ok  = c_ident_ok;
        n_has_comma = c_has_comma;
        n_line      = c_line;
        n_lc_line   = c_lc_line;
        n_tok_cnt   = c_tok_cnt;
        n_cm_in     = c_cm_in;
        n_cm_block  = c_cm_block;
        n_cm_linev  = c_cm_linev;
        if (!ws) begin
            for (int k = 0; k < NUM_WORDS; k++) begin
                n_words[k] = c_words[k] && (pos16 < 16'(WORD_LEN[k])) &&
                             (to_lower(b) == word_char(k, pos16[2:0]));
            end
            if (pos16 >= 16'd1 && !(is_digit(b) || b == CH_DOT)) begin
                n_num_ok = 1'b0;
            end
            if (!is_ident_byte(b)) begin
                n_ident_ok = 1'b0;
            end
            if (b == CH_COMMA) begin
                n_has_comma = 1'b1;
            end
            if (pos16 == 16'd0) begin
                n_first = {8'h00, b};
            end else if (pos16 == 16'd1) begin
                n_first = {b, c_first[7:0]};
            end
            n_last = {c_last[7:0], b};
            if (c_byte_cnt < CNT_MAX) begin
                n_byte_cnt = c_byte_cnt + CW'(1);
            end
            if (b == CH_COMMA) begin
                if (c_comma_cnt < CNT_MAX) begin
                    n_comma_cnt = c_comma_cnt + CW'(1);
                end
            end else if (c_clean_cnt < CNT_MAX) begin
                n_clean_cnt = c_clean_cnt + CW'(1);
            end
        end else if (o_emit) begin
            n_cm_in    = cm_in_cls;
            n_cm_block = c_cm_block || open_blk;
            n_cm_linev = c_cm_linev || open_line;
            if (open_line) begin
                n_lc_line = c_line;
            end
            if (close_blk) begin
                n_cm_in    = 1'b0;
                n_cm_block = 1'b0;
            end
            if (b == CH_LF || b == CH_CR) begin
                n_line = line_inc;
            end
            // line comment ends once a token finishes on a later line
            if (n_cm_linev && (n_line > n_lc_line) && !n_cm_block) begin
                n_cm_in = 1'b0;
            end
            if (c_tok_cnt != 16'hFFFF) begin
                n_tok_cnt = c_tok_cnt + 16'd1;
            end
            n_byte_cnt  = '0;
            n_comma_cnt = '0;
            n_clean_cnt = '0;
            n_first     = '0;
            n_last      = '0;
            n_words     = '1;
            n_num_ok    = 1'b1;
            n_ident_ok  = 1'b1;
            n_has_comma = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_cnt  <= '0;
            r_comma_cnt <= '0;
            r_clean_cnt <= '0;
            r_first     <= '0;
            r_last      <= '0;
            r_words     <= '1;
            r_num_ok    <= 1'b1;
            r_ident_ok  <= 1'b1;
            r_has_comma <= 1'b0;
            r_line      <= '0;
            r_lc_line   <= '0;
            r_tok_cnt   <= '0;
            r_cm_in     <= 1'b0;
            r_cm_block  <= 1'b0;
            r_cm_linev  <= 1'b0;
        end else if (i_adv) begin
            r_byte_cnt  <= n_byte_cnt;
            r_comma_cnt <= n_comma_cnt;
            r_clean_cnt <= n_clean_cnt;
            r_first     <= n_first;
            r_last      <= n_last;
            r_words     <= n_words;
            r_num_ok    <= n_num_ok;
            r_ident_ok  <= n_ident_ok;
            r_has_comma <= n_has_comma;
            r_line      <= n_line;
            r_lc_line   <= n_lc_line;
            r_tok_cnt   <= n_tok_cnt;
            r_cm_in     <= n_cm_in;
            r_cm_block  <= n_cm_block;
            r_cm_linev  <= n_cm_linev;
        end
    end

    a_first_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_adv && sot && !ws |=> r_byte_cnt == CW'(1))
        else $error("token length not restarted at start of text");

    a_clean_le_raw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clean_cnt <= r_byte_cnt)
        else $error("clean length exceeds raw length");

    a_block_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cm_block |-> r_cm_in)
        else $error("block comment open without comment flag");

    a_class_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_emit |-> o_res.token_class <= CLS_COMMENT)
        else $error("token class out of range");

endmodule

>>> rtl/core/sql_token_classifier.sv
// SQL token classifier: one text byte per transaction in, one result per token out.
//
// Input channel (i_in_valid / o_in_ready / i_in_data) carries one byte of SQL text
// and a start_of_text flag that clears line, comment and token state before the
// byte is handled. Space, tab, CR and LF close a non-empty token; each closed
// token gives one transaction on the output channel (o_out_valid / i_out_ready /
// o_out_data) with class, line, clean and raw length and token index. Other
// bytes give no result. A trailing token without whitespace is never emitted.
// The configuration channel (i_cfg_valid / o_cfg_ready / i_cfg_data) sets the
// index of the first token after the next start_of_text; it is always ready.
// A token's closing byte is taken into the input register, and its result then
// into the result register. Throughput: one byte per cycle while the receiver
// does not stall; per-byte state update is combinational flag/counter logic.
// If the receiver stalls, the result register holds and the input register
// fills, after which o_in_ready falls; nothing is dropped.
// Reset (synchronous, active low) empties both registers, returns all token, line,
// comment and counter state to its defaults and first_token_index to zero.
module sql_token_classifier #(
    parameter int MAX_TOKEN_LEN = stc_pkg::MAX_TOKEN_LEN_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  stc_pkg::t_in_item   i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output stc_pkg::t_out_item  o_out_data,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [15:0]         i_cfg_data
);
    import stc_pkg::*;

    logic        r_s0_valid;
    t_in_item    r_s0_item;
    logic        r_out_valid;
    t_out_item   r_out_item;
    logic [15:0] r_first_idx;
    logic        s0_adv;
    logic        emit;
    t_out_item   res;

    assign s0_adv      = r_s0_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_s0_valid || s0_adv;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_item;

    stc_scan #(
        .MAX_TOKEN_LEN (MAX_TOKEN_LEN)
    ) u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (s0_adv),
        .i_item      (r_s0_item),
        .i_first_idx (r_first_idx),
        .o_emit      (emit),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_first_idx <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_first_idx <= i_cfg_data;
            end
            if (i_in_valid && o_in_ready) begin
                r_s0_valid <= 1'b1;
            end else if (s0_adv) begin
                r_s0_valid <= 1'b0;
            end
            if (s0_adv) begin
                r_out_valid <= emit;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_s0_item <= i_in_data;
        end
        if (s0_adv && emit) begin
            r_out_item <= res;
        end
    end

endmodule
